// File: hw/rtl/utf8_to_utf16_utf32_decoder_assert.svh
// ----------------------------------------------------------------------------
// utf8_to_utf16_utf32_decoder assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_UTF32_DECODER_ASSERT_SVH

// same-cycle implication
`define U8DEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u8dec assertion failed");

// next-cycle implication
`define U8DEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u8dec assertion failed");

`endif

// File: hw/rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// types and constants shared by the utf-8 decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

    localparam int UNIT_W   = 31;
    localparam int HALF_W   = 16;
    localparam int CNT_W    = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [PADDR_W-1:0] REG_OUT_UTF32 = 3'd0;

    localparam logic [HALF_W-1:0] REPL_CHAR  = 16'hFFFD;
    localparam logic [HALF_W-1:0] HI_SURR    = 16'hD800;
    localparam logic [HALF_W-1:0] LO_SURR    = 16'hDC00;
    localparam logic [20:0]       MAX_CODE   = 21'h10FFFF;
    localparam logic [25:0]       PLANE1     = 26'h0010000;
    localparam logic [5:0]        CONT_MASK  = 6'h3F;

    typedef struct packed {
        logic              push;
        logic [UNIT_W-1:0] unit0;
        logic [HALF_W-1:0] unit1;
        logic              two;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/u8dec_regs.sv
// ----------------------------------------------------------------------------
// u8dec_regs
// apb register block holding the output mode bit
// ----------------------------------------------------------------------------
`default_nettype none

module u8dec_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u8dec_pkg::PADDR_W-1:0] paddr,
    input  wire logic [u8dec_pkg::PDATA_W-1:0] pwdata,
    output logic      [u8dec_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output logic                               o_out_utf32
);

    logic r_out_utf32;
    logic n_out_utf32;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == u8dec_pkg::REG_OUT_UTF32);

    always_comb begin
        n_out_utf32 = r_out_utf32;
        if (wr_hit) begin
            n_out_utf32 = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_utf32 <= 1'b0;
        end else begin
            r_out_utf32 <= n_out_utf32;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == u8dec_pkg::REG_OUT_UTF32) begin
            prdata = {{(u8dec_pkg::PDATA_W-1){1'b0}}, r_out_utf32};
        end
    end

    assign o_out_utf32 = r_out_utf32;

endmodule

`default_nettype wire

// File: hw/rtl/u8dec_core.sv
// ----------------------------------------------------------------------------
// u8dec_core
// sequence state and per-byte decode into one or two result units
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_utf32_decoder_assert.svh"

module u8dec_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_take,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_out_utf32,
    output u8dec_pkg::t_result        o_result
);

    logic [u8dec_pkg::CNT_W-1:0]  r_bytes_left, n_bytes_left;
    logic [u8dec_pkg::CNT_W-1:0]  r_seq_length, n_seq_length;
    logic [u8dec_pkg::UNIT_W-1:0] r_payload,    n_payload;

    logic [u8dec_pkg::UNIT_W-1:0] cont_val;
    logic [u8dec_pkg::CNT_W-1:0]  left_dec;
    logic [25:0]                  diff;
    u8dec_pkg::t_result           res;

    assign cont_val = {r_payload[u8dec_pkg::UNIT_W-7:0], i_in_byte[5:0] & u8dec_pkg::CONT_MASK};
    assign left_dec = r_bytes_left - 3'd1;
    assign diff     = cont_val[25:0] - u8dec_pkg::PLANE1;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq_length = r_seq_length;
        n_payload    = r_payload;
        res.push     = 1'b0;
        res.unit0    = {15'd0, u8dec_pkg::REPL_CHAR};
        res.unit1    = u8dec_pkg::LO_SURR;
        res.two      = 1'b0;
        if (r_bytes_left != 3'd0) begin
            n_payload    = cont_val;
            n_bytes_left = left_dec;
            if (left_dec == 3'd0) begin
                n_seq_length = 3'd0;
                n_payload    = '0;
                res.push     = 1'b1;
                if (i_out_utf32) begin
                    res.unit0 = cont_val;
                end else if (r_seq_length <= 3'd3) begin
                    res.unit0 = {15'd0, cont_val[15:0]};
                end else if (r_seq_length == 3'd4) begin
                    if (cont_val <= {10'd0, u8dec_pkg::MAX_CODE}) begin
                        res.unit0 = {15'd0, diff[25:10] | u8dec_pkg::HI_SURR};
                        res.unit1 = u8dec_pkg::LO_SURR | {6'd0, cont_val[9:0]};
                        res.two   = 1'b1;
                    end
                end
            end
        end else begin
            case (i_in_byte) inside
                [8'h00:8'h7F]: begin
                    res.push  = 1'b1;
                    res.unit0 = {23'd0, i_in_byte};
                end
                [8'hC0:8'hDF]: begin
                    n_payload    = {26'd0, i_in_byte[4:0]};
                    n_seq_length = 3'd2;
                    n_bytes_left = 3'd1;
                end
                [8'hE0:8'hEF]: begin
                    n_payload    = {27'd0, i_in_byte[3:0]};
                    n_seq_length = 3'd3;
                    n_bytes_left = 3'd2;
                end
                [8'hF0:8'hF7]: begin
                    n_payload    = {28'd0, i_in_byte[2:0]};
                    n_seq_length = 3'd4;
                    n_bytes_left = 3'd3;
                end
                [8'hF8:8'hFB]: begin
                    n_payload    = {29'd0, i_in_byte[1:0]};
                    n_seq_length = 3'd5;
                    n_bytes_left = 3'd4;
                end
                [8'hFC:8'hFD]: begin
                    n_payload    = {30'd0, i_in_byte[0]};
                    n_seq_length = 3'd6;
                    n_bytes_left = 3'd5;
                end
                default: begin
                    res.push = 1'b1;
                end
            endcase
        end
        res.push = res.push && i_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_seq_length <= '0;
            r_payload    <= '0;
        end else if (i_take) begin
            r_bytes_left <= n_bytes_left;
            r_seq_length <= n_seq_length;
            r_payload    <= n_payload;
        end
    end

    assign o_result = res;

    `U8DEC_ASSERT_NOW(a_left_below_len, r_bytes_left != 3'd0, r_seq_length > r_bytes_left)
    `U8DEC_ASSERT_NOW(a_idle_clear, r_bytes_left == 3'd0, r_seq_length == 3'd0)
    `U8DEC_ASSERT_NEXT(a_lead_opens, i_take && r_bytes_left == 3'd0 && !o_result.push,
        r_bytes_left != 3'd0)

endmodule

`default_nettype wire

// File: hw/rtl/u8dec_queue.sv
// ----------------------------------------------------------------------------
// u8dec_queue
// two-record result queue, each record giving one or two output transfers
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_utf32_decoder_assert.svh"

module u8dec_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  u8dec_pkg::t_result                 i_result,
    output logic                               o_space,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [u8dec_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                               o_run_last
);

    logic [u8dec_pkg::UNIT_W-1:0] r_unit0 [2];
    logic [u8dec_pkg::HALF_W-1:0] r_unit1 [2];
    logic                         r_two   [2];
    logic                         r_wptr, n_wptr;
    logic                         r_rptr, n_rptr;
    logic                         r_sel,  n_sel;
    logic [1:0]                   r_count, n_count;
    logic                         xfer;
    logic                         pop;

    assign o_space     = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_run_last  = !r_two[r_rptr] || r_sel;
    assign o_code_unit = r_sel ? {15'd0, r_unit1[r_rptr]} : r_unit0[r_rptr];
    assign xfer        = o_out_valid && i_out_ready;
    assign pop         = xfer && o_run_last;

    always_comb begin
        n_wptr  = r_wptr ^ i_result.push;
        n_rptr  = r_rptr ^ pop;
        n_sel   = xfer ? !o_run_last : r_sel;
        n_count = r_count + {1'b0, i_result.push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_sel   <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_sel   <= n_sel;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.push) begin
            r_unit0[r_wptr] <= i_result.unit0;
            r_unit1[r_wptr] <= i_result.unit1;
            r_two[r_wptr]   <= i_result.two;
        end
    end

    `U8DEC_ASSERT_NEXT(a_pair_follows, xfer && !o_run_last, o_out_valid && o_run_last)
    `U8DEC_ASSERT_NOW(a_pair_head_16b, o_out_valid && !o_run_last,
        o_code_unit[u8dec_pkg::UNIT_W-1:u8dec_pkg::HALF_W] == '0)
    `U8DEC_ASSERT_NEXT(a_push_shows, i_result.push && r_count == 2'd0, o_out_valid)

endmodule

`default_nettype wire

// File: hw/rtl/utf8_to_utf16_utf32_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_utf32_decoder
// streaming utf-8 decoder producing utf-16 units or utf-32 code points
// ----------------------------------------------------------------------------
//   channel  signals                               direction
//   in       i_in_valid  o_in_ready  i_in_byte     byte stream in
//   out      o_out_valid i_out_ready o_code_unit   results out, o_run_last
//   cfg      psel penable pwrite paddr pwdata ...  apb, mode bit at 0x0
//
//   one byte per cycle while the queue has space; a byte is decoded in the cycle it is taken
//   a surrogate pair takes two output transfers
//   the two-record result queue sets input ready; stalls on out back up into it
//   synchronous active-low reset clears sequence state and mode, no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_utf32_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_in_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [u8dec_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                               o_run_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u8dec_pkg::PADDR_W-1:0] paddr,
    input  wire logic [u8dec_pkg::PDATA_W-1:0] pwdata,
    output logic      [u8dec_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);

    logic               out_utf32;
    logic               space;
    logic               take;
    u8dec_pkg::t_result result;

    assign o_in_ready = space;
    assign take       = i_in_valid && space;

    u8dec_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_out_utf32 (out_utf32)
    );

    u8dec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_in_byte   (i_in_byte),
        .i_out_utf32 (out_utf32),
        .o_result    (result)
    );

    u8dec_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code_unit (o_code_unit),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire

// File: tb/tb_utf8_to_utf16_utf32_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_utf32_decoder
// feeds utf-8 byte streams through the decoder in both output modes, predicts
// every utf-16 unit or utf-32 code point in step with the byte transfers, and
// checks each output transfer in order under random sender gaps and stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_to_utf16_utf32_decoder;

    localparam int          UNIT_W       = u8dec_pkg::UNIT_W;
    localparam int          PADDR_W      = u8dec_pkg::PADDR_W;
    localparam int          PDATA_W      = u8dec_pkg::PDATA_W;
    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_BYTES = 1520;
    localparam int          PHASE_COUNT  = 12;
    localparam int          DRAIN_CYCLES = 6;
    localparam longint      RUN_LIMIT_NS = 5_000_000;
    localparam logic [UNIT_W-1:0] REPL_UNIT = UNIT_W'(u8dec_pkg::REPL_CHAR);

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } t_decoded_unit;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [7:0]          i_in_byte   = 8'h00;
    logic                i_out_ready = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    wire                 o_in_ready;
    wire                 o_out_valid;
    wire  [UNIT_W-1:0]   o_code_unit;
    wire                 o_run_last;
    wire  [PDATA_W-1:0]  prdata;
    wire                 pready;

    utf8_to_utf16_utf32_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code_unit (o_code_unit),
        .o_run_last  (o_run_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted decoder state
    logic              mode_utf32   = 1'b0;
    logic [2:0]        pend_left    = '0;
    logic [2:0]        pend_len     = '0;
    logic [UNIT_W-1:0] pend_payload = '0;

    logic [7:0]      utf8_stream[$];
    t_decoded_unit   expected_units[$];

    logic            in_taken  = 1'b0;
    int              burst_max = 8;
    int              gap_max   = 0;
    int              burst_left = 1;
    int              gap_left   = 0;
    logic [15:0]     ready_pat = 16'hFFFF;
    logic [3:0]      ready_idx = '0;

    int error_count  = 0;
    int bytes_taken  = 0;
    int units_seen   = 0;
    int pair_count   = 0;
    int repl_count   = 0;
    int mode_writes  = 0;
    int utf32_writes = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 25)
            $display("%0t ns mismatch %s: got 0x%h expected 0x%h", $time, what, got, want);
        error_count++;
    endtask

    task automatic emit_unit(input logic [UNIT_W-1:0] value, input logic last);
        t_decoded_unit item;
        item.unit = value;
        item.last = last;
        expected_units.push_back(item);
        if (value == REPL_UNIT) repl_count++;
        if (!last) pair_count++;
    endtask

    task automatic open_form(input logic [2:0] len, input logic [UNIT_W-1:0] bits);
        pend_len     = len;
        pend_payload = bits;
        pend_left    = len - 3'd1;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [UNIT_W-1:0] v;
        logic [31:0]       off;
        if (pend_left != 0) begin
            pend_payload = {pend_payload[UNIT_W-7:0], b[5:0]};
            pend_left    = pend_left - 3'd1;
            if (pend_left == 0) begin
                v = pend_payload;
                if (mode_utf32) begin
                    emit_unit(v, 1'b1);
                end else if (pend_len <= 3'd3) begin
                    emit_unit(UNIT_W'(v[15:0]), 1'b1);
                end else if (pend_len == 3'd4) begin
                    if (v > UNIT_W'(u8dec_pkg::MAX_CODE)) begin
                        emit_unit(REPL_UNIT, 1'b1);
                    end else begin
                        off = {1'b0, v} - 32'(u8dec_pkg::PLANE1);
                        emit_unit(UNIT_W'(off[25:10] | u8dec_pkg::HI_SURR), 1'b0);
                        emit_unit(UNIT_W'({6'b0, v[9:0]} | u8dec_pkg::LO_SURR), 1'b1);
                    end
                end else begin
                    emit_unit(REPL_UNIT, 1'b1);
                end
                pend_len     = '0;
                pend_payload = '0;
            end
        end else begin
            casez (b)
                8'b0???????: emit_unit(UNIT_W'(b), 1'b1);
                8'b110?????: open_form(3'd2, UNIT_W'(b[4:0]));
                8'b1110????: open_form(3'd3, UNIT_W'(b[3:0]));
                8'b11110???: open_form(3'd4, UNIT_W'(b[2:0]));
                8'b111110??: open_form(3'd5, UNIT_W'(b[1:0]));
                8'b1111110?: open_form(3'd6, UNIT_W'(b[0]));
                default:     emit_unit(REPL_UNIT, 1'b1);
            endcase
        end
    endtask

    // byte transfers feed the prediction before the result transfer of the same edge is checked
    always @(posedge i_clk) begin
        t_decoded_unit want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_in_byte);
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                units_seen++;
                if (expected_units.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(o_code_unit), 32'hx);
                end else begin
                    want = expected_units.pop_front();
                    if (o_code_unit !== want.unit)
                        report_mismatch("code_unit", 32'(o_code_unit), 32'(want.unit));
                    if (o_run_last !== want.last)
                        report_mismatch("run_last", 32'(o_run_last), 32'(want.last));
                end
            end
        end
    end

    // byte sender, bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (utf8_stream.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_byte  <= utf8_stream.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left   = $urandom_range(0, gap_max);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, rotating stall pattern
    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n ? ready_pat[ready_idx] : 1'b0;
        ready_idx   <= ready_idx + 4'd1;
    end

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(input logic utf32);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, u8dec_pkg::REG_OUT_UTF32, PDATA_W'(utf32), rd);
        mode_utf32 = utf32;
        mode_writes++;
        if (utf32) utf32_writes++;
        apb_access(1'b0, u8dec_pkg::REG_OUT_UTF32, '0, rd);
        if (rd[0] !== utf32)
            report_mismatch("out_utf32 readback", rd, PDATA_W'(utf32));
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (utf8_stream.size() != 0 || i_in_valid || expected_units.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // encode a value as a len-byte form, keeping only the first n_bytes
    task automatic push_form(input logic [UNIT_W-1:0] cp, input int len,
                             input bit odd_tops, input int n_bytes);
        logic [7:0] lead;
        logic [1:0] tops;
        int         k;
        if (len == 1)
            lead = {1'b0, cp[6:0]};
        else
            lead = ~(8'hFF >> len) | (8'(cp >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
        utf8_stream.push_back(lead);
        for (k = len - 2; k >= 0 && (len - 1 - k) < n_bytes; k--) begin
            tops = odd_tops ? 2'($urandom) : 2'b10;
            utf8_stream.push_back({tops, 6'(cp >> (6 * k))});
        end
    endtask

    task automatic push_random_item();
        int                pick;
        int                sel;
        int                len;
        bit                odd;
        logic [UNIT_W-1:0] cp;
        pick = $urandom_range(0, 99);
        odd  = ($urandom_range(0, 9) == 0);
        if (pick < 28) begin
            push_form(UNIT_W'($urandom_range(0, 32'h7F)), 1, 1'b0, 1);
        end else if (pick < 42) begin
            push_form(UNIT_W'($urandom_range(0, 32'h7FF)), 2, odd, 2);
        end else if (pick < 56) begin
            push_form(UNIT_W'($urandom_range(0, 32'hFFFF)), 3, odd, 3);
        end else if (pick < 74) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                cp = UNIT_W'($urandom_range(32'h10000, 32'h10FFFF));
            else if (sel < 8)
                cp = UNIT_W'($urandom_range(32'h110000, 32'h1FFFFF));
            else
                cp = UNIT_W'($urandom_range(0, 32'hFFFF));
            push_form(cp, 4, odd, 4);
        end else if (pick < 79) begin
            push_form(UNIT_W'($urandom_range(0, 32'h3FFFFFF)), 5, odd, 5);
        end else if (pick < 84) begin
            push_form(UNIT_W'($urandom), 6, odd, 6);
        end else if (pick < 91) begin
            utf8_stream.push_back(8'($urandom));
        end else if (pick < 96) begin
            sel = $urandom_range(0, 2);
            if (sel == 0)
                utf8_stream.push_back(8'hFE);
            else if (sel == 1)
                utf8_stream.push_back(8'hFF);
            else
                utf8_stream.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
            // truncated form, the following bytes finish it
            len = $urandom_range(2, 6);
            push_form(UNIT_W'($urandom), len, odd, $urandom_range(1, len - 1));
        end
    endtask

    initial begin
        int p;
        int len;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(1'b0);
        // ascii nul, stray continuation, ff lead, 2-byte max,
        // above plane 16, overlong 4-byte
        utf8_stream = '{8'h00, 8'h80, 8'hFF, 8'hDF, 8'hBF,
                        8'hF4, 8'h90, 8'h80, 8'h80,
                        8'hF0, 8'h80, 8'h80, 8'h80};
        wait_drained();

        set_mode(1'b1);
        // largest 6-byte value, 5-byte form with unchecked continuation tops,
        // then a 4-byte form left open across the mode change
        utf8_stream = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                        8'hF8, 8'hFF, 8'h00, 8'hC0, 8'h7F,
                        8'hF4, 8'h8F};
        wait_drained();

        for (p = 0; p < PHASE_COUNT; p++) begin
            set_mode(p < 2 ? p[0] : 1'($urandom));
            burst_max = $urandom_range(1, 24);
            gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
            ready_pat = (p % 4 == 1) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            if (p == 0) begin
                utf8_stream.push_back(8'hBF);
                utf8_stream.push_back(8'hBF);
            end
            while (utf8_stream.size() < RANDOM_BYTES / PHASE_COUNT)
                push_random_item();
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(2, 6);
                push_form(UNIT_W'($urandom), len, 1'b0, $urandom_range(1, len - 1));
            end
            wait_drained();
        end

        $display("decoded %0d bytes into %0d checked transfers, %0d surrogate pairs, %0d U+FFFD",
                 bytes_taken, units_seen, pair_count, repl_count);
        $display("mode register written %0d times, %0d of them selecting utf-32 output",
                 mode_writes, utf32_writes);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d transfers outstanding", expected_units.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_regs.sv
hw/rtl/u8dec_core.sv
hw/rtl/u8dec_queue.sv
hw/rtl/utf8_to_utf16_utf32_decoder.sv
tb/tb_utf8_to_utf16_utf32_decoder.sv
